[sv/ssc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_pkg: shared types, widths and helpers for segment closest points
// Widths of the coordinate, dot product, wide product and divider datapaths,
// the payload words of both channels and the item word between the parts.
// ----------------------------------------------------------------------------
package ssc_pkg;

   localparam int COORD_W    = 16;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int DOT_W      = 2 * DIFF_W + 2;
   localparam int WIDE_W     = 2 * DOT_W - 2;
   localparam int DIV_W      = WIDE_W - 1;
   localparam int PFRAC      = 16;
   localparam int PARAM_W    = PFRAC + 1;
   localparam int TN_W       = DOT_W + PARAM_W + 3;
   localparam int CPROD_W    = DIFF_W + PARAM_W + 1;
   localparam int DIST_W     = 2 * COORD_W + 2;
   localparam int LIMIT_W    = 16;
   localparam int DIV_STAGES = PFRAC + 1;
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [DOT_W-1:0]   dot_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;
   typedef logic signed [TN_W-1:0]    tn_type;
   typedef logic signed [CPROD_W-1:0] cprod_type;
   typedef logic [PARAM_W-1:0]        param_type;
   typedef logic [DIV_W-1:0]          div_type;
   typedef logic [DIST_W-1:0]         dist_type;

   localparam param_type PARAM_ONE = PARAM_W'(1 << PFRAC);

   typedef struct packed {
      coord_type p1_x;
      coord_type p1_y;
      coord_type p1_z;
      coord_type q1_x;
      coord_type q1_y;
      coord_type q1_z;
      coord_type p2_x;
      coord_type p2_y;
      coord_type p2_z;
      coord_type q2_x;
      coord_type q2_y;
      coord_type q2_z;
   } req_type;

   typedef struct packed {
      param_type seg1_param;
      param_type seg2_param;
      coord_type closest1_x;
      coord_type closest1_y;
      coord_type closest1_z;
      coord_type closest2_x;
      coord_type closest2_y;
      coord_type closest2_z;
      dist_type  dist_squared;
   } rsp_type;

   typedef struct packed {
      coord_type [2:0] p1;
      coord_type [2:0] p2;
      diff_type [2:0]  d1;
      diff_type [2:0]  d2;
      dot_type         a;
      dot_type         b;
      dot_type         c;
      dot_type         e;
      dot_type         f;
      logic            deg1;
      logic            deg2;
   } fr_item_type;

   typedef struct packed {
      fr_item_type geo;
      param_type   s_val;
      param_type   t_val;
      logic        s_div;
      logic        t_div;
   } bk_item_type;

   function automatic diff_type coord_diff(coord_type hi, coord_type lo);
      return DIFF_W'(hi) - DIFF_W'(lo);
   endfunction

   function automatic dot_type dot3(diff_type u0, diff_type u1, diff_type u2,
                                    diff_type v0, diff_type v1, diff_type v2);
      logic signed [2*DIFF_W-1:0] m0;
      logic signed [2*DIFF_W-1:0] m1;
      logic signed [2*DIFF_W-1:0] m2;
      m0 = u0 * v0;
      m1 = u1 * v1;
      m2 = u2 * v2;
      return DOT_W'(m0) + DOT_W'(m1) + DOT_W'(m2);
   endfunction

   function automatic wide_type wide_mul(dot_type x, dot_type y);
      logic signed [2*DOT_W-1:0] m;
      m = x * y;
      return WIDE_W'(m);
   endfunction

   function automatic tn_type tn_calc(dot_type b, dot_type f, param_type s);
      logic signed [DOT_W+PARAM_W:0] m;
      m = b * $signed({1'b0, s});
      return TN_W'(m) + (TN_W'(f) <<< PFRAC);
   endfunction

   function automatic cprod_type cprod(diff_type d, param_type s);
      return CPROD_W'(d) * $signed({1'b0, s});
   endfunction

   // truncate toward zero, then offset from the start point
   function automatic coord_type scale_add(coord_type p, cprod_type m);
      cprod_type adj;
      cprod_type q;
      adj = m;
      if (m < 0) begin
         adj = m + $signed({{(CPROD_W-PFRAC){1'b0}}, {PFRAC{1'b1}}});
      end
      q = adj >>> PFRAC;
      return COORD_W'(DIFF_W'(p) + DIFF_W'(q));
   endfunction

   function automatic dist_type square(diff_type d);
      logic signed [2*DIFF_W-1:0] m;
      m = d * d;
      return DIST_W'(m);
   endfunction

endpackage
`default_nettype wire

[sv/ssc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_front: input stages
// Forms edge and offset vectors, the five dot products and the point tests.
// ----------------------------------------------------------------------------
module ssc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  ssc_pkg::req_type             in_data,
   input  logic [ssc_pkg::LIMIT_W-1:0]  limit,
   output logic                         out_valid,
   output ssc_pkg::fr_item_type         out_item
);
   import ssc_pkg::*;

   logic      v1_ff, v2_ff, v3_ff;
   coord_type p1_in [3];
   coord_type q1_in [3];
   coord_type p2_in [3];
   coord_type q2_in [3];
   coord_type p1_ff [3];
   coord_type p2_ff [3];
   diff_type  d1_ff [3];
   diff_type  d2_ff [3];
   diff_type  r_ff [3];
   fr_item_type it2_in, it2_ff, it3_in, it3_ff;
   dot_type     lim_ext;

   always_comb begin
      p1_in[0] = in_data.p1_x; p1_in[1] = in_data.p1_y; p1_in[2] = in_data.p1_z;
      q1_in[0] = in_data.q1_x; q1_in[1] = in_data.q1_y; q1_in[2] = in_data.q1_z;
      p2_in[0] = in_data.p2_x; p2_in[1] = in_data.p2_y; p2_in[2] = in_data.p2_z;
      q2_in[0] = in_data.q2_x; q2_in[1] = in_data.q2_y; q2_in[2] = in_data.q2_z;
   end

   always_comb begin
      it2_in      = '0;
      for (int i = 0; i < 3; i++) begin
         it2_in.p1[i] = p1_ff[i];
         it2_in.p2[i] = p2_ff[i];
         it2_in.d1[i] = d1_ff[i];
         it2_in.d2[i] = d2_ff[i];
      end
      it2_in.a = dot3(d1_ff[0], d1_ff[1], d1_ff[2], d1_ff[0], d1_ff[1], d1_ff[2]);
      it2_in.e = dot3(d2_ff[0], d2_ff[1], d2_ff[2], d2_ff[0], d2_ff[1], d2_ff[2]);
      it2_in.b = dot3(d1_ff[0], d1_ff[1], d1_ff[2], d2_ff[0], d2_ff[1], d2_ff[2]);
      it2_in.c = dot3(d1_ff[0], d1_ff[1], d1_ff[2], r_ff[0], r_ff[1], r_ff[2]);
      it2_in.f = dot3(d2_ff[0], d2_ff[1], d2_ff[2], r_ff[0], r_ff[1], r_ff[2]);
   end

   always_comb begin
      lim_ext     = $signed({{(DOT_W-LIMIT_W){1'b0}}, limit});
      it3_in      = it2_ff;
      it3_in.deg1 = it2_ff.a <= lim_ext;
      it3_in.deg2 = it2_ff.e <= lim_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            p1_ff[i] <= p1_in[i];
            p2_ff[i] <= p2_in[i];
            d1_ff[i] <= coord_diff(q1_in[i], p1_in[i]);
            d2_ff[i] <= coord_diff(q2_in[i], p2_in[i]);
            r_ff[i]  <= coord_diff(p1_in[i], p2_in[i]);
         end
         it2_ff <= it2_in;
         it3_ff <= it3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_item  = it3_ff;

endmodule
`default_nettype wire

[sv/ssc_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_queue: short queue between front and back
// Decouples the two stall domains; head word is shown while not empty.
// ----------------------------------------------------------------------------
module ssc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ssc_pkg::fr_item_type  push_item,
   input  logic                  pop,
   output logic                  full,
   output logic                  empty,
   output ssc_pkg::fr_item_type  head
);
   import ssc_pkg::*;

   fr_item_type         mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full  = count_ff == (QPTR_W+1)'(QDEPTH);
   assign empty = count_ff == '0;
   assign head  = mem_ff[rd_ptr_ff];

endmodule
`default_nettype wire

[sv/ssc_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_div: pipelined restoring divider
// Quotient of {hi, lo} by den, one quotient bit per stage, 17 bits in all.
// hi must stay below twice den; the item word rides along.
// ----------------------------------------------------------------------------
module ssc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [ssc_pkg::DIV_W-1:0]    in_hi,
   input  logic [ssc_pkg::PFRAC-1:0]    in_lo,
   input  logic [ssc_pkg::DIV_W-1:0]    in_den,
   input  ssc_pkg::bk_item_type         in_item,
   output logic                         out_valid,
   output logic [ssc_pkg::PARAM_W-1:0]  out_q,
   output ssc_pkg::bk_item_type         out_item
);
   import ssc_pkg::*;

   logic [DIV_STAGES-1:0] valid_ff;
   div_type               rem_ff [DIV_STAGES];
   div_type               rem_in [DIV_STAGES];
   div_type               den_ff [DIV_STAGES];
   logic [PFRAC-1:0]      lo_ff [DIV_STAGES];
   param_type             q_ff [DIV_STAGES];
   param_type             q_in [DIV_STAGES];
   bk_item_type           item_ff [DIV_STAGES];
   logic [DIV_W:0]        cand [DIV_STAGES];
   logic                  ge [DIV_STAGES];

   always_comb begin
      cand[0]   = {1'b0, in_hi};
      ge[0]     = cand[0] >= {1'b0, in_den};
      rem_in[0] = ge[0] ? DIV_W'(cand[0] - {1'b0, in_den}) : DIV_W'(cand[0]);
      q_in[0]   = {{(PARAM_W-1){1'b0}}, ge[0]};
      for (int j = 1; j < DIV_STAGES; j++) begin
         // bring down the next dividend bit
         cand[j]   = {rem_ff[j-1], lo_ff[j-1][PFRAC-j]};
         ge[j]     = cand[j] >= {1'b0, den_ff[j-1]};
         rem_in[j] = ge[j] ? DIV_W'(cand[j] - {1'b0, den_ff[j-1]}) : DIV_W'(cand[j]);
         q_in[j]   = {q_ff[j-1][PARAM_W-2:0], ge[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= rem_in[0];
         q_ff[0]    <= q_in[0];
         den_ff[0]  <= in_den;
         lo_ff[0]   <= in_lo;
         item_ff[0] <= in_item;
         for (int j = 1; j < DIV_STAGES; j++) begin
            rem_ff[j]  <= rem_in[j];
            q_ff[j]    <= q_in[j];
            den_ff[j]  <= den_ff[j-1];
            lo_ff[j]   <= lo_ff[j-1];
            item_ff[j] <= item_ff[j-1];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_q     = q_ff[DIV_STAGES-1];
   assign out_item  = item_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

[sv/ssc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_back: solver stages
// Wide products, the general-case division for s, clamping of t, the second
// division, closest points and squared distance. Stalls as one on adv.
// ----------------------------------------------------------------------------
module ssc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  ssc_pkg::fr_item_type  in_item,
   output logic                  out_valid,
   output ssc_pkg::rsp_type      out_rsp
);
   import ssc_pkg::*;

   // stage 1: wide products
   logic        b1_v_ff;
   fr_item_type b1_item_ff;
   wide_type    ae_ff, bb_ff, bf_ff, ce_ff;
   // stage 2: determinant and numerator
   logic        b2_v_ff;
   fr_item_type b2_item_ff;
   wide_type    denom_ff, num_ff;
   // first division setup
   bk_item_type dv1_item;
   div_type     dv1_hi, dv1_den;
   logic        dv1_ok, dv1_one;
   logic        e1_v;
   param_type   e1_q;
   bk_item_type e1_item;
   // stage 4: s and the t numerator
   logic        b4_v_ff;
   bk_item_type b4_item_ff, b4_item_in;
   tn_type      tn_ff;
   // second division setup
   bk_item_type dv2_item;
   div_type     dv2_hi, dv2_den;
   logic [PFRAC-1:0] dv2_lo;
   logic        gen, tneg, tbig, to_t, to_s, rpos, rge, rdiv;
   dot_type     rn, rd;
   param_type   rval;
   logic        e2_v;
   param_type   e2_q;
   bk_item_type e2_item;
   // stage 6: products along the edges
   logic        b6_v_ff;
   param_type   s_in, t_in, s6_ff, t6_ff, s7_ff, t7_ff;
   coord_type   p1_6_ff [3];
   coord_type   p2_6_ff [3];
   cprod_type   m1_ff [3];
   cprod_type   m2_ff [3];
   // stage 7: closest points
   logic        b7_v_ff;
   coord_type   c1_ff [3];
   coord_type   c2_ff [3];
   dist_type    dist_sum;

   always_comb begin
      dv1_item       = '0;
      dv1_item.geo   = b2_item_ff;
      dv1_ok         = !b2_item_ff.deg1 && !b2_item_ff.deg2 && (denom_ff != '0)
                       && (num_ff > 0);
      dv1_one        = dv1_ok && (num_ff >= denom_ff);
      dv1_item.s_div = dv1_ok && !dv1_one;
      dv1_item.s_val = dv1_one ? PARAM_ONE : '0;
      dv1_hi         = dv1_item.s_div ? DIV_W'(num_ff) : '0;
      dv1_den        = dv1_item.s_div ? DIV_W'(denom_ff) : DIV_W'(1);
   end

   ssc_div u_div_s (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (b2_v_ff),
      .in_hi     (dv1_hi),
      .in_lo     ('0),
      .in_den    (dv1_den),
      .in_item   (dv1_item),
      .out_valid (e1_v),
      .out_q     (e1_q),
      .out_item  (e1_item)
   );

   always_comb begin
      b4_item_in       = e1_item;
      b4_item_in.s_val = e1_item.s_div ? e1_q : e1_item.s_val;
      b4_item_in.s_div = 1'b0;
   end

   always_comb begin
      gen   = !b4_item_ff.geo.deg1 && !b4_item_ff.geo.deg2;
      tneg  = tn_ff < 0;
      tbig  = tn_ff > (TN_W'(b4_item_ff.geo.e) <<< PFRAC);
      to_t  = b4_item_ff.geo.deg1 && !b4_item_ff.geo.deg2;
      to_s  = (b4_item_ff.geo.deg2 && !b4_item_ff.geo.deg1) || (gen && (tneg || tbig));
      if (to_t) begin
         rn = b4_item_ff.geo.f;
      end else if (gen && tbig) begin
         rn = b4_item_ff.geo.b - b4_item_ff.geo.c;
      end else begin
         rn = -b4_item_ff.geo.c;
      end
      rd    = to_t ? b4_item_ff.geo.e : b4_item_ff.geo.a;
      rpos  = rn > 0;
      rge   = rn >= rd;
      rdiv  = rpos && !rge;
      rval  = (rpos && rge) ? PARAM_ONE : '0;

      dv2_item = b4_item_ff;
      dv2_hi   = '0;
      dv2_lo   = '0;
      dv2_den  = DIV_W'(1);
      if (b4_item_ff.geo.deg1 && b4_item_ff.geo.deg2) begin
         dv2_item.s_val = '0;
         dv2_item.t_val = '0;
      end else if (to_t) begin
         dv2_item.s_val = '0;
         dv2_item.t_div = rdiv;
         dv2_item.t_val = rval;
         dv2_hi         = rdiv ? DIV_W'(rn) : '0;
         dv2_den        = DIV_W'(rd);
      end else if (to_s) begin
         dv2_item.s_div = rdiv;
         dv2_item.s_val = rval;
         dv2_item.t_val = (gen && tbig) ? PARAM_ONE : '0;
         dv2_hi         = rdiv ? DIV_W'(rn) : '0;
         dv2_den        = DIV_W'(rd);
      end else begin
         // t inside the segment: divide the full numerator by e
         dv2_item.t_div = 1'b1;
         dv2_hi         = DIV_W'(tn_ff >>> PFRAC);
         dv2_lo         = tn_ff[PFRAC-1:0];
         dv2_den        = DIV_W'(b4_item_ff.geo.e);
      end
   end

   ssc_div u_div_t (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (b4_v_ff),
      .in_hi     (dv2_hi),
      .in_lo     (dv2_lo),
      .in_den    (dv2_den),
      .in_item   (dv2_item),
      .out_valid (e2_v),
      .out_q     (e2_q),
      .out_item  (e2_item)
   );

   always_comb begin
      s_in = e2_item.s_div ? e2_q : e2_item.s_val;
      t_in = e2_item.t_div ? e2_q : e2_item.t_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0;
         b2_v_ff <= 1'b0;
         b4_v_ff <= 1'b0;
         b6_v_ff <= 1'b0;
         b7_v_ff <= 1'b0;
      end else if (adv) begin
         b1_v_ff <= in_valid;
         b2_v_ff <= b1_v_ff;
         b4_v_ff <= e1_v;
         b6_v_ff <= e2_v;
         b7_v_ff <= b6_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_item_ff <= in_item;
         ae_ff      <= wide_mul(in_item.a, in_item.e);
         bb_ff      <= wide_mul(in_item.b, in_item.b);
         bf_ff      <= wide_mul(in_item.b, in_item.f);
         ce_ff      <= wide_mul(in_item.c, in_item.e);
         b2_item_ff <= b1_item_ff;
         denom_ff   <= ae_ff - bb_ff;
         num_ff     <= bf_ff - ce_ff;
         b4_item_ff <= b4_item_in;
         tn_ff      <= tn_calc(e1_item.geo.b, e1_item.geo.f, b4_item_in.s_val);
         s6_ff      <= s_in;
         t6_ff      <= t_in;
         for (int i = 0; i < 3; i++) begin
            p1_6_ff[i] <= e2_item.geo.p1[i];
            p2_6_ff[i] <= e2_item.geo.p2[i];
            m1_ff[i]   <= cprod(e2_item.geo.d1[i], s_in);
            m2_ff[i]   <= cprod(e2_item.geo.d2[i], t_in);
            c1_ff[i]   <= scale_add(p1_6_ff[i], m1_ff[i]);
            c2_ff[i]   <= scale_add(p2_6_ff[i], m2_ff[i]);
         end
         s7_ff <= s6_ff;
         t7_ff <= t6_ff;
      end
   end

   always_comb begin
      dist_sum = '0;
      for (int i = 0; i < 3; i++) begin
         dist_sum = dist_sum + square(coord_diff(c1_ff[i], c2_ff[i]));
      end
   end

   always_comb begin
      out_rsp.seg1_param   = s7_ff;
      out_rsp.seg2_param   = t7_ff;
      out_rsp.closest1_x   = c1_ff[0];
      out_rsp.closest1_y   = c1_ff[1];
      out_rsp.closest1_z   = c1_ff[2];
      out_rsp.closest2_x   = c2_ff[0];
      out_rsp.closest2_y   = c2_ff[1];
      out_rsp.closest2_z   = c2_ff[2];
      out_rsp.dist_squared = dist_sum;
   end

   assign out_valid = b7_v_ff;

endmodule
`default_nettype wire

[sv/segment_segment_closest_points.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// segment_segment_closest_points: closest points between two 3D segments
// Pushes a pair of segments in, pops s, t, both closest points and squared distance.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: a word is taken at a clock edge with req_push high
//   and req_full low. Results come out as a queue: the oldest result is on
//   rsp_data while rsp_empty is low and leaves on an edge with rsp_pop high.
//   csr_we loads csr_wdata into the point-length limit on any edge.
//   Throughput is one word per cycle while req_full is low. A word passes
//   three input stages, the four-entry queue, two wide product stages, two
//   17-stage pipelined dividers with the t numerator stage between them,
//   two point stages and the output register before its result shows on
//   rsp_data. When a result sits unpopped and pop is held low the solver
//   pipeline holds; the input stages keep taking words until the middle
//   queue fills, then req_full rises.
//   Synchronous reset empties all stages and clears the limit to zero.
// ----------------------------------------------------------------------------
module segment_segment_closest_points (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  ssc_pkg::req_type             req_data,
   output logic                         req_full,
   output logic                         rsp_empty,
   output ssc_pkg::rsp_type             rsp_data,
   input  logic                         rsp_pop,
   input  logic                         csr_we,
   input  logic [ssc_pkg::LIMIT_W-1:0]  csr_wdata
);
   import ssc_pkg::*;

   logic [LIMIT_W-1:0] limit_ff;
   logic               fr_adv, bk_adv, accept;
   logic               fr_valid, q_full, q_empty, q_push, q_pop;
   fr_item_type        fr_item, q_head;
   logic               bk_valid;
   rsp_type            bk_rsp;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   assign fr_adv   = !q_full;
   assign accept   = req_push && !q_full;
   assign q_push   = fr_valid && fr_adv;
   // advance the solver unless a result sits unpopped
   assign bk_adv   = !rsp_valid_ff || rsp_pop;
   assign q_pop    = bk_adv && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   ssc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (fr_adv),
      .in_valid  (accept),
      .in_data   (req_data),
      .limit     (limit_ff),
      .out_valid (fr_valid),
      .out_item  (fr_item)
   );

   ssc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (fr_item),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   ssc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (bk_adv),
      .in_valid  (!q_empty),
      .in_item   (q_head),
      .out_valid (bk_valid),
      .out_rsp   (bk_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (bk_adv) begin
         rsp_valid_ff <= bk_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (bk_adv) begin
         rsp_data_ff <= bk_rsp;
      end
   end

   assign req_full  = q_full;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: segment pair closest points testbench
// Streams segment pairs through the queue ports with random gaps and stalls,
// predicts s, t, both closest points and the squared distance in the bench,
// and compares every popped word field by field in order. The point-length
// limit is swept through several settings, its extremes among them.
// ----------------------------------------------------------------------------
module tb;
   import ssc_pkg::*;

   localparam longint ONE = 64'sd65536;
   localparam int     LATENCY = 44;
   localparam longint CYCLE_LIMIT = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   req_type     req_data = '0;
   logic        req_full;
   logic        rsp_empty;
   rsp_type     rsp_data;
   logic        rsp_pop = 1'b0;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   rsp_type     expected_q[$];
   logic [15:0] point_limit = '0;
   int          fail_count = 0;
   longint      cycle_count = 0;
   bit          sending_done = 1'b0;

   segment_segment_closest_points DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_data(rsp_data), .rsp_pop(rsp_pop),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   // clamp n/d into [0, ONE], truncating
   function automatic longint clamp_ratio(input longint n, input longint d);
      if (d <= 0 || n <= 0) return 0;
      if (n >= d) return ONE;
      return (n * ONE) / d;
   endfunction

   function automatic longint wide_ratio(input logic signed [127:0] n,
                                         input logic signed [127:0] d);
      if (d <= 0 || n <= 0) return 0;
      if (n >= d) return ONE;
      return longint'((n * ONE) / d);
   endfunction

   function automatic rsp_type closest_points(input req_type w);
      longint p1[3], q1[3], p2[3], q2[3], d1[3], d2[3], r[3];
      longint a, b, c, e, f, s, t, tn, c1, c2, diff;
      logic signed [127:0] den;
      logic [63:0] dist_sum;
      rsp_type res;
      p1 = '{w.p1_x, w.p1_y, w.p1_z};
      q1 = '{w.q1_x, w.q1_y, w.q1_z};
      p2 = '{w.p2_x, w.p2_y, w.p2_z};
      q2 = '{w.q2_x, w.q2_y, w.q2_z};
      a = 0; b = 0; c = 0; e = 0; f = 0; s = 0; t = 0; dist_sum = 0;
      for (int i = 0; i < 3; i++) begin
         d1[i] = q1[i] - p1[i];
         d2[i] = q2[i] - p2[i];
         r[i] = p1[i] - p2[i];
         a += d1[i] * d1[i];
         e += d2[i] * d2[i];
         b += d1[i] * d2[i];
         c += d1[i] * r[i];
         f += d2[i] * r[i];
      end
      if (a <= point_limit && e <= point_limit) begin
         s = 0; t = 0;
      end else if (a <= point_limit) begin
         t = clamp_ratio(f, e);
      end else if (e <= point_limit) begin
         s = clamp_ratio(-c, a);
      end else begin
         den = 128'(a) * 128'(e) - 128'(b) * 128'(b);
         s = (den != 0) ? wide_ratio(128'(b) * 128'(f) - 128'(c) * 128'(e), den) : 0;
         tn = b * s + f * ONE;
         if (tn < 0) begin
            t = 0; s = clamp_ratio(-c, a);
         end else if (tn > e * ONE) begin
            t = ONE; s = clamp_ratio(b - c, a);
         end else begin
            t = tn / e;
         end
      end
      res.seg1_param = param_type'(s);
      res.seg2_param = param_type'(t);
      for (int i = 0; i < 3; i++) begin
         c1 = p1[i] + (d1[i] * s) / ONE;
         c2 = p2[i] + (d2[i] * t) / ONE;
         diff = c1 - c2;
         dist_sum += diff * diff;
         case (i)
            0: begin res.closest1_x = coord_type'(c1); res.closest2_x = coord_type'(c2); end
            1: begin res.closest1_y = coord_type'(c1); res.closest2_y = coord_type'(c2); end
            default: begin
               res.closest1_z = coord_type'(c1); res.closest2_z = coord_type'(c2);
            end
         endcase
      end
      res.dist_squared = dist_type'(dist_sum);
      return res;
   endfunction

   task automatic send_word(input req_type w);
      repeat ($urandom_range(0, 12)) @(negedge clock);
      req_data = w;
      req_push = 1'b1;
      do @(posedge clock); while (req_full);
      expected_q.push_back(closest_points(w));
      @(negedge clock);
      req_push = 1'b0;
   endtask

   task automatic set_limit(input logic [15:0] v);
      wait (expected_q.size() == 0);
      repeat (LATENCY + 4) @(negedge clock);
      csr_wdata = v;
      csr_we = 1'b1;
      @(negedge clock);
      csr_we = 1'b0;
      point_limit = v;
   endtask

   // pop side: random stalls before each word, compare against oldest
   initial begin
      rsp_type want;
      @(negedge clock);
      forever begin
         repeat ($urandom_range(0, 12)) @(negedge clock);
         rsp_pop = 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (expected_q.size() == 0) begin
            report("unexpected word", 0, 0);
         end else begin
            want = expected_q.pop_front();
            if (rsp_data.seg1_param !== want.seg1_param)
               report("seg1_param", rsp_data.seg1_param, want.seg1_param);
            if (rsp_data.seg2_param !== want.seg2_param)
               report("seg2_param", rsp_data.seg2_param, want.seg2_param);
            if (rsp_data.closest1_x !== want.closest1_x)
               report("closest1_x", rsp_data.closest1_x, want.closest1_x);
            if (rsp_data.closest1_y !== want.closest1_y)
               report("closest1_y", rsp_data.closest1_y, want.closest1_y);
            if (rsp_data.closest1_z !== want.closest1_z)
               report("closest1_z", rsp_data.closest1_z, want.closest1_z);
            if (rsp_data.closest2_x !== want.closest2_x)
               report("closest2_x", rsp_data.closest2_x, want.closest2_x);
            if (rsp_data.closest2_y !== want.closest2_y)
               report("closest2_y", rsp_data.closest2_y, want.closest2_y);
            if (rsp_data.closest2_z !== want.closest2_z)
               report("closest2_z", rsp_data.closest2_z, want.closest2_z);
            if (rsp_data.dist_squared !== want.dist_squared)
               report("dist_squared", rsp_data.dist_squared, want.dist_squared);
         end
         @(negedge clock);
         rsp_pop = 1'b0;
      end
   end

   function automatic coord_type rand_coord(input int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(0, 2047)) - 16'sd1024;
         2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return coord_type'($urandom_range(0, 15)) - 16'sd8;
      endcase
   endfunction

   function automatic req_type rand_word();
      req_type w;
      int m;
      m = $urandom_range(0, 3);
      w = '{rand_coord(m), rand_coord(m), rand_coord(m), rand_coord(m), rand_coord(m),
            rand_coord(m), rand_coord(m), rand_coord(m), rand_coord(m), rand_coord(m),
            rand_coord(m), rand_coord(m)};
      case ($urandom_range(0, 7))
         // point-like first segment
         0: begin w.q1_x = w.p1_x; w.q1_y = w.p1_y; w.q1_z = w.p1_z; end
         // point-like second segment
         1: begin w.q2_x = w.p2_x; w.q2_y = w.p2_y; w.q2_z = w.p2_z; end
         // parallel: second is a shifted copy of the first
         2: begin
            w.p2_x = w.p1_x + 16'sd64; w.p2_y = w.p1_y; w.p2_z = w.p1_z + 16'sd3;
            w.q2_x = w.q1_x + 16'sd64; w.q2_y = w.q1_y; w.q2_z = w.q1_z + 16'sd3;
         end
         default: ;
      endcase
      return w;
   endfunction

   // directed rows; a known result is given where it is obvious
   typedef struct {
      req_type w;
      bit      known;
      rsp_type want;
   } row_type;

   row_type directed[$];

   initial begin
      row_type row;
      logic [15:0] limits[5];
      directed.push_back('{'0, 1'b1, '0});
      // both segments points at the extremes: s = t = 0, C = P
      row.w = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
      row.known = 1'b1;
      row.want = '{17'd0, 17'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                   16'sh8000, 16'sh8000, 16'sh8000, 34'd12884508675};
      directed.push_back(row);
      row.known = 1'b0;
      row.w = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
      directed.push_back(row);
      // first segment a point, second a line across it
      row.w = '{0, 256, 0, 0, 256, 0, -512, 0, 0, 512, 0, 0};
      directed.push_back(row);
      // second a point
      row.w = '{-512, 0, 0, 512, 0, 0, 0, 256, 0, 0, 256, 0};
      directed.push_back(row);
      // parallel, overlapping
      row.w = '{0, 0, 0, 1024, 0, 0, 256, 256, 0, 768, 256, 0};
      directed.push_back(row);
      // crossing, interior solution
      row.w = '{-256, 0, 0, 256, 0, 0, 0, -256, 128, 0, 256, 128};
      directed.push_back(row);
      // t below zero and above one
      row.w = '{0, 0, 0, 256, 0, 0, 0, 512, 0, 0, 1024, 0};
      directed.push_back(row);
      row.w = '{0, 0, 0, 256, 0, 0, 0, -1024, 0, 0, -512, 0};
      directed.push_back(row);
      // skew at the ends of both
      row.w = '{16'sh8000, 0, 0, 16'sh7fff, 0, 0, 0, 16'sh8000, 200, 0, 16'sh7fff, -200};
      directed.push_back(row);
      row.w = '{1, 1, 1, 2, 1, 1, 1, 2, 1, 1, 3, 1};
      directed.push_back(row);

      repeat (5) @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         send_word(directed[i].w);
         if (directed[i].known && expected_q[$] != directed[i].want)
            report("directed row", i, 0);
      end
      // tiny segments fall under the limit
      set_limit(16'd4);
      for (int i = 9; i < directed.size(); i++) send_word(directed[i].w);

      limits = '{16'hffff, 16'd0, 16'd300, 16'h8000, 16'd65};
      foreach (limits[k]) begin
         set_limit(limits[k]);
         repeat (400) send_word(rand_word());
      end
      set_limit(16'd0);

      wait (expected_q.size() == 0);
      repeat (LATENCY + 10) @(negedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
